### design/sfxd_pkg.sv
// sfxd_pkg: types, constants and helpers for the sync/footer xor deframer
// used by sync_footer_xor_deframer; no dependencies
package sfxd_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 4096;

  localparam int unsigned COUNT_W = 13;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TDATA_W = 48;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'hF0;
  localparam logic [7:0] FOOT_B = 8'h0F;
  localparam logic [7:0] KEY_RESET = 8'hCA;
  localparam logic [COUNT_W-1:0] EMIT_RESET = COUNT_W'(1024);
  localparam logic [COUNT_W-1:0] ABORT_RESET = COUNT_W'(4090);
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAME_BYTES);

  localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABORT_LIMIT = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
  localparam logic [1:0] STATUS_ABORTED = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [7:0]         data;
    logic [7:0]         msg_type;
    logic [7:0]         seq_tag;
    logic [7:0]         len_byte;
    logic [COUNT_W-1:0] payload_count;
    logic [1:0]         status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               abort;
    logic               emit;
    logic [7:0]         data;
  } take_t;

  // count one raw payload byte and decide emit or abort
  function automatic take_t take_byte(input logic [COUNT_W-1:0] cnt,
                                      input logic [7:0] raw,
                                      input logic [7:0] key,
                                      input logic [COUNT_W-1:0] emit_lim,
                                      input logic [COUNT_W-1:0] abort_lim);
    take_t t;
    t.count = cnt + COUNT_W'(1);
    t.abort = (t.count >= abort_lim);
    t.emit = !t.abort && (t.count <= emit_lim);
    t.data = raw ^ key;
    return t;
  endfunction

endpackage

### design/sync_footer_xor_deframer.sv
// sync_footer_xor_deframer: byte stream deframer, sync AA F0, footer AA 0F
// depends on sfxd_pkg
//
//   channel   | direction | tdata / tuser / tlast
//   s_*       | in        | tdata[7:0] in_byte
//   m_*       | out       | tdata data, msg_type, seq_tag, len_byte, payload_count,
//             |           |   status, pad; tuser kind; tlast last
//   cfg_*     | in        | index 0 xor_key, 1 emit_limit, 2 abort_limit
//
// one input byte per cycle; the frame state updates in the accept cycle and the
// results of that byte (up to two) enter a four-entry output queue, from which
// one result leaves per cycle while m_tready is high. a byte causing two results
// costs two output beats. s_tready is low while fewer than two entries are free.
// rst is synchronous and restores the register reset values and hunting state.
module sync_footer_xor_deframer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // in_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // data, msg_type, seq_tag, len_byte, payload_count, status, zero pad
  output logic [sfxd_pkg::TDATA_W-1:0]  m_tdata,
  output logic                          m_tuser,   // kind
  output logic                          m_tlast,   // last
  input  logic                          cfg_we,
  input  logic [sfxd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfxd_pkg::CFG_W-1:0]    cfg_data
);
  import sfxd_pkg::*;

  typedef enum logic [1:0] {HUNT0, HUNT1, HEAD, BODY} phase_t;

  logic [7:0]         xor_key;
  logic [COUNT_W-1:0] emit_limit;
  logic [COUNT_W-1:0] abort_limit;

  phase_t             phase, phase_next;
  logic [1:0]         header_index, header_index_next;
  logic [7:0]         type_reg, type_reg_next;
  logic [7:0]         tag_reg, tag_reg_next;
  logic [7:0]         length_reg, length_reg_next;
  logic               held_aa, held_aa_next;
  logic [COUNT_W-1:0] raw_count, raw_count_next;

  result_t            res [2];
  logic [1:0]         res_n;

  result_t            fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0] fill;

  logic               accept, pop;
  logic [COUNT_W-1:0] eff_abort;
  logic [7:0]         b;
  take_t              t1, t2;
  result_t            end_rec, pay_rec;
  logic               ended;

  assign accept = s_tvalid && s_tready;
  assign pop = m_tvalid && m_tready;
  assign s_tready = (fill <= FIFO_CW'(FIFO_DEPTH - 2));
  assign m_tvalid = (fill != '0);
  assign eff_abort = (abort_limit < MAX_COUNT) ? abort_limit : MAX_COUNT;
  assign b = s_tdata;

  always_comb begin
    phase_next = phase;
    header_index_next = header_index;
    type_reg_next = type_reg;
    tag_reg_next = tag_reg;
    length_reg_next = length_reg;
    held_aa_next = held_aa;
    raw_count_next = raw_count;
    res[0] = '0;
    res[1] = '0;
    res_n = 2'd0;
    ended = 1'b0;
    t1 = take_byte(raw_count, SYNC_A, xor_key, emit_limit, eff_abort);
    t2 = take_byte(held_aa ? t1.count : raw_count, b, xor_key, emit_limit, eff_abort);
    end_rec = '0;
    end_rec.kind = KIND_FRAME_END;
    end_rec.msg_type = type_reg;
    end_rec.seq_tag = tag_reg;
    end_rec.len_byte = length_reg;
    pay_rec = '0;
    pay_rec.kind = KIND_PAYLOAD;

    unique case (phase)
      HUNT0: begin
        phase_next = (b == SYNC_A) ? HUNT1 : HUNT0;
      end
      HUNT1: begin
        if (b == SYNC_B) begin
          phase_next = HEAD;
          header_index_next = 2'd0;
        end else begin
          phase_next = (b == SYNC_A) ? HUNT1 : HUNT0;
        end
      end
      HEAD: begin
        unique case (header_index)
          2'd0: length_reg_next = b;
          2'd1: tag_reg_next = b;
          2'd2: type_reg_next = b;
          default: ;
        endcase
        if (header_index == 2'd3) begin
          phase_next = BODY;
          header_index_next = 2'd0;
          raw_count_next = '0;
          held_aa_next = 1'b0;
        end else begin
          header_index_next = header_index + 2'd1;
        end
      end
      BODY: begin
        if (held_aa) begin
          held_aa_next = 1'b0;
          if (b == FOOT_B) begin
            end_rec.payload_count = raw_count;
            end_rec.status = (raw_count > emit_limit) ? STATUS_TRUNCATED : STATUS_OK;
            res[0] = end_rec;
            res_n = 2'd1;
            phase_next = HUNT0;
            ended = 1'b1;
          end else begin
            raw_count_next = t1.count;
            if (t1.abort) begin
              end_rec.payload_count = t1.count;
              end_rec.status = STATUS_ABORTED;
              res[0] = end_rec;
              res_n = 2'd1;
              phase_next = (b == SYNC_A) ? HUNT1 : HUNT0;
              ended = 1'b1;
            end else if (t1.emit) begin
              pay_rec.data = t1.data;
              res[0] = pay_rec;
              res_n = 2'd1;
            end
          end
        end
        if (!ended) begin
          if (b == SYNC_A) begin
            held_aa_next = 1'b1;
          end else begin
            raw_count_next = t2.count;
            if (t2.abort) begin
              end_rec.payload_count = t2.count;
              end_rec.status = STATUS_ABORTED;
              res[res_n[0]] = end_rec;
              res_n = res_n + 2'd1;
              phase_next = HUNT0;
              held_aa_next = 1'b0;
            end else if (t2.emit) begin
              pay_rec.data = t2.data;
              res[res_n[0]] = pay_rec;
              res_n = res_n + 2'd1;
            end
          end
        end
      end
      default: phase_next = HUNT0;
    endcase

    if (res_n == 2'd2) begin
      res[1].last = 1'b1;
    end else if (res_n == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xor_key <= KEY_RESET;
      emit_limit <= EMIT_RESET;
      abort_limit <= ABORT_RESET;
      phase <= HUNT0;
      header_index <= 2'd0;
      type_reg <= '0;
      tag_reg <= '0;
      length_reg <= '0;
      held_aa <= 1'b0;
      raw_count <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_XOR_KEY: xor_key <= cfg_data[7:0];
          CFG_EMIT_LIMIT: emit_limit <= cfg_data;
          CFG_ABORT_LIMIT: abort_limit <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        phase <= phase_next;
        header_index <= header_index_next;
        type_reg <= type_reg_next;
        tag_reg <= tag_reg_next;
        length_reg <= length_reg_next;
        held_aa <= held_aa_next;
        raw_count <= raw_count_next;
        wr_ptr <= wr_ptr + FIFO_AW'(res_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fill <= fill + (accept ? FIFO_CW'(res_n) : FIFO_CW'(0)) - FIFO_CW'(pop);
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (accept && res_n != 2'd0) begin
      fifo[wr_ptr] <= res[0];
    end
    if (accept && res_n == 2'd2) begin
      fifo[wr_ptr + FIFO_AW'(1)] <= res[1];
    end
  end

  assign m_tdata = {1'b0, fifo[rd_ptr].status, fifo[rd_ptr].payload_count,
                    fifo[rd_ptr].len_byte, fifo[rd_ptr].seq_tag,
                    fifo[rd_ptr].msg_type, fifo[rd_ptr].data};
  assign m_tuser = fifo[rd_ptr].kind;
  assign m_tlast = fifo[rd_ptr].last;

endmodule
